@@ rtl/tagged_word_stream_monitor_unit_macros.svh @@
// Assertion macros for the tagged word stream monitor.
// Used by the top level; needs clk and rst_n in scope.
`ifndef TAGGED_WORD_STREAM_MONITOR_UNIT_MACROS_SVH
`define TAGGED_WORD_STREAM_MONITOR_UNIT_MACROS_SVH

// cond must hold at every edge outside reset
`define TWSM_ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// conseq must hold in the cycle after trig
`define TWSM_ASSERT_NEXT(label, trig, conseq, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (conseq)) \
    else $error(msg);

`endif

@@ rtl/twsm_pkg.sv @@
// Shared types and constants for the tagged word stream monitor.
// No dependencies.
package twsm_pkg;

  localparam int COUNT_BITS = 32;   // internal counter width, 16..64
  localparam int OUT_CNT_W  = 32;
  localparam int WORD_W     = 16;
  localparam int CFG_IDX_W  = 2;

  typedef logic [COUNT_BITS-1:0] cnt_t;
  typedef logic [WORD_W-1:0]     word_t;
  typedef logic [OUT_CNT_W-1:0]  out_cnt_t;
  typedef logic [CFG_IDX_W-1:0]  cfg_idx_t;

  localparam word_t END_OF_EVENT  = 16'hFFFF;
  localparam word_t MATCH_ID_RST  = 16'h8001;
  localparam word_t RANGE_LO_RST  = 16'd1;
  localparam word_t RANGE_HI_RST  = 16'd8191;
  localparam word_t MIN_VALUE_RST = 16'hFFFF;

  localparam cfg_idx_t REG_MATCH_ID   = 2'd0;
  localparam cfg_idx_t REG_RANGE_LOW  = 2'd1;
  localparam cfg_idx_t REG_RANGE_HIGH = 2'd2;

  // one classified item, front to back
  typedef struct packed {
    logic  end_of_event;
    logic  id_match;
    logic  in_range;
    logic  buffer_start;
    word_t value;
  } twsm_rec_t;

endpackage

@@ rtl/twsm_front.sv @@
// Front end: configuration registers and item classification.
// Depends on twsm_pkg.
module twsm_front (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  twsm_pkg::cfg_idx_t       cfg_index,
  input  twsm_pkg::word_t          cfg_data,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  twsm_pkg::word_t          in_id_word,
  input  twsm_pkg::word_t          in_value_word,
  input  logic                     in_buffer_start,
  output logic                     push_valid,
  input  logic                     push_ready,
  output twsm_pkg::twsm_rec_t      push_rec
);
  import twsm_pkg::*;

  word_t match_id_r;
  word_t range_low_r;
  word_t range_high_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      match_id_r   <= MATCH_ID_RST;
      range_low_r  <= RANGE_LO_RST;
      range_high_r <= RANGE_HI_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_MATCH_ID:   match_id_r   <= cfg_data;
        REG_RANGE_LOW:  range_low_r  <= cfg_data;
        REG_RANGE_HIGH: range_high_r <= cfg_data;
        default: ;  // unmapped index, write dropped
      endcase
    end
  end

  assign in_ready   = push_ready;
  assign push_valid = in_valid;

  always_comb begin
    push_rec.end_of_event = (in_id_word == END_OF_EVENT);
    push_rec.id_match     = (in_id_word == match_id_r);
    push_rec.in_range     = (in_value_word >= range_low_r) &&
                            (in_value_word <= range_high_r);
    push_rec.buffer_start = in_buffer_start;
    push_rec.value        = in_value_word;
  end

endmodule

@@ rtl/twsm_queue.sv @@
// Two-entry queue of classified items between front and back.
// Depends on twsm_pkg.
module twsm_queue (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push_valid,
  output logic                 push_ready,
  input  twsm_pkg::twsm_rec_t  push_rec,
  output logic                 pop_valid,
  input  logic                 pop_ready,
  output twsm_pkg::twsm_rec_t  pop_rec
);
  import twsm_pkg::*;

  twsm_rec_t  entry0_r;
  twsm_rec_t  entry1_r;
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] count_r, count_nxt;
  logic       do_push, do_pop;

  assign push_ready = (count_r != 2'd2);
  assign pop_valid  = (count_r != 2'd0);
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;
  assign pop_rec    = rd_ptr_r ? entry1_r : entry0_r;

  always_comb begin
    wr_ptr_nxt = do_push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = do_pop  ? ~rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r + {1'b0, do_push} - {1'b0, do_pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push && !wr_ptr_r) entry0_r <= push_rec;
    if (do_push &&  wr_ptr_r) entry1_r <= push_rec;
  end

endmodule

@@ rtl/twsm_back.sv @@
// Back end: statistics counters and the result register.
// Depends on twsm_pkg.
module twsm_back (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 pop_valid,
  output logic                 pop_ready,
  input  twsm_pkg::twsm_rec_t  pop_rec,
  output logic                 out_valid,
  input  logic                 out_ready,
  output twsm_pkg::out_cnt_t   out_events_seen,
  output twsm_pkg::out_cnt_t   out_id_matches,
  output twsm_pkg::out_cnt_t   out_in_range_matches,
  output twsm_pkg::word_t      out_min_value,
  output twsm_pkg::word_t      out_max_value,
  output twsm_pkg::word_t      out_most_per_event,
  output twsm_pkg::out_cnt_t   out_duplicate_events
);
  import twsm_pkg::*;

  function automatic cnt_t sat_inc(input cnt_t v);
    sat_inc = (v == '1) ? v : v + cnt_t'(1);
  endfunction

  logic  out_valid_r, out_valid_nxt;
  cnt_t  event_cnt_r, event_cnt_nxt;
  cnt_t  match_cnt_r, match_cnt_nxt;
  cnt_t  range_cnt_r, range_cnt_nxt;
  cnt_t  dup_cnt_r, dup_cnt_nxt;
  word_t min_r, min_nxt;
  word_t max_r, max_nxt;
  word_t cur_r, cur_nxt;
  word_t peak_r, peak_nxt;
  word_t cur_start;
  logic  do_pop;

  // stats only move on a pop, so they always equal the shown snapshot
  assign pop_ready = !out_valid_r || out_ready;
  assign do_pop    = pop_valid && pop_ready;

  always_comb begin
    event_cnt_nxt = event_cnt_r;
    match_cnt_nxt = match_cnt_r;
    range_cnt_nxt = range_cnt_r;
    dup_cnt_nxt   = dup_cnt_r;
    min_nxt       = min_r;
    max_nxt       = max_r;
    peak_nxt      = peak_r;
    cur_start     = pop_rec.buffer_start ? '0 : cur_r;
    cur_nxt       = cur_start;
    out_valid_nxt = out_valid_r && !out_ready;
    if (do_pop) begin
      out_valid_nxt = 1'b1;
      if (pop_rec.end_of_event) begin
        event_cnt_nxt = sat_inc(event_cnt_r);
        if (cur_start > peak_r) peak_nxt = cur_start;
        if (cur_start > word_t'(1)) dup_cnt_nxt = sat_inc(dup_cnt_r);
        cur_nxt = '0;
      end
      // a delimiter equal to match_id also opens the next event
      if (pop_rec.id_match) begin
        if (cur_nxt != '1) cur_nxt = cur_nxt + word_t'(1);
        if (pop_rec.in_range) range_cnt_nxt = sat_inc(range_cnt_r);
        if (pop_rec.value < min_r) min_nxt = pop_rec.value;
        if (pop_rec.value > max_r) max_nxt = pop_rec.value;
        match_cnt_nxt = sat_inc(match_cnt_r);
      end
    end else begin
      cur_nxt = cur_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      event_cnt_r <= '0;
      match_cnt_r <= '0;
      range_cnt_r <= '0;
      dup_cnt_r   <= '0;
      min_r       <= MIN_VALUE_RST;
      max_r       <= '0;
      cur_r       <= '0;
      peak_r      <= '0;
    end else begin
      out_valid_r <= out_valid_nxt;
      event_cnt_r <= event_cnt_nxt;
      match_cnt_r <= match_cnt_nxt;
      range_cnt_r <= range_cnt_nxt;
      dup_cnt_r   <= dup_cnt_nxt;
      min_r       <= min_nxt;
      max_r       <= max_nxt;
      cur_r       <= cur_nxt;
      peak_r      <= peak_nxt;
    end
  end

  assign out_valid            = out_valid_r;
  assign out_events_seen      = out_cnt_t'(event_cnt_r);
  assign out_id_matches       = out_cnt_t'(match_cnt_r);
  assign out_in_range_matches = out_cnt_t'(range_cnt_r);
  assign out_duplicate_events = out_cnt_t'(dup_cnt_r);
  assign out_min_value        = min_r;
  assign out_max_value        = max_r;
  assign out_most_per_event   = peak_r;

endmodule

@@ rtl/tagged_word_stream_monitor_unit.sv @@
// Top level of the tagged word stream monitor.
// Depends on twsm_pkg, twsm_front, twsm_queue, twsm_back and the macros header.
//
// Takes one (id, value) pair per item and returns one statistics snapshot per
// item. Sustained rate is one item per clock while out_ready stays high. An
// accepted item waits in the two-entry queue until the back end takes it; the
// back end then folds it into its counters, and the same edge loads the result
// register. The front end classifies the pair against the configuration
// registers; the back end updates its counters for each item that it takes.
// in_ready drops only when the queue holds two items, which happens when the
// result register is stalled.
// Configuration writes are always taken (cfg_ready is tied high); write only
// while no item is in flight. Indexes beyond range_high are ignored.
module tagged_word_stream_monitor_unit (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  twsm_pkg::cfg_idx_t  cfg_index,
  input  twsm_pkg::word_t     cfg_data,
  input  logic                in_valid,
  output logic                in_ready,
  input  twsm_pkg::word_t     in_id_word,
  input  twsm_pkg::word_t     in_value_word,
  input  logic                in_buffer_start,
  output logic                out_valid,
  input  logic                out_ready,
  output twsm_pkg::out_cnt_t  out_events_seen,
  output twsm_pkg::out_cnt_t  out_id_matches,
  output twsm_pkg::out_cnt_t  out_in_range_matches,
  output twsm_pkg::word_t     out_min_value,
  output twsm_pkg::word_t     out_max_value,
  output twsm_pkg::word_t     out_most_per_event,
  output twsm_pkg::out_cnt_t  out_duplicate_events
);
  import twsm_pkg::*;

  `include "tagged_word_stream_monitor_unit_macros.svh"

  logic      push_valid, push_ready;
  twsm_rec_t push_rec;
  logic      pop_valid, pop_ready;
  twsm_rec_t pop_rec;

  twsm_front u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_id_word      (in_id_word),
    .in_value_word   (in_value_word),
    .in_buffer_start (in_buffer_start),
    .push_valid      (push_valid),
    .push_ready      (push_ready),
    .push_rec        (push_rec)
  );

  twsm_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_rec   (push_rec),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_rec    (pop_rec)
  );

  twsm_back u_back (
    .clk                  (clk),
    .rst_n                (rst_n),
    .pop_valid            (pop_valid),
    .pop_ready            (pop_ready),
    .pop_rec              (pop_rec),
    .out_valid            (out_valid),
    .out_ready            (out_ready),
    .out_events_seen      (out_events_seen),
    .out_id_matches       (out_id_matches),
    .out_in_range_matches (out_in_range_matches),
    .out_min_value        (out_min_value),
    .out_max_value        (out_max_value),
    .out_most_per_event   (out_most_per_event),
    .out_duplicate_events (out_duplicate_events)
  );

  // an accepted item is held in the queue until the back end takes it
  `TWSM_ASSERT_NEXT(a_accept_queued, in_valid && in_ready, pop_valid,
                    "accepted item not queued")
  // every item taken by the back end shows a result next cycle
  `TWSM_ASSERT_NEXT(a_pop_shows, pop_valid && pop_ready, out_valid,
                    "popped item has no result")
  // once any match is counted, min and max are ordered
  `TWSM_ASSERT_ALWAYS(a_min_le_max,
                      (out_id_matches == '0) || (out_min_value <= out_max_value),
                      "min above max after a match")
  // with no match yet, min and max keep their reset values
  `TWSM_ASSERT_ALWAYS(a_no_match_ext,
                      (out_id_matches != '0) ||
                      ((out_min_value == MIN_VALUE_RST) && (out_max_value == '0)),
                      "min or max moved without a match")

endmodule

@@ bench/tagged_word_stream_monitor_unit_tb.sv @@
// Self-checking testbench for tagged_word_stream_monitor_unit.
// Needs twsm_pkg and the RTL. Predicts each statistics snapshot in step with
// accepted pairs and compares it field by field with the block's results.
module tagged_word_stream_monitor_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import twsm_pkg::*;

  localparam int LATENCY       = 2;
  localparam int SETTLE_CYCLES = LATENCY + 4;
  localparam int HOLD_CYCLES   = 64;
  localparam int DRAIN_LIMIT   = 50000;
  localparam int MAX_SHOWN     = 10;
  localparam cfg_idx_t REG_UNUSED = 2'd3;

  typedef struct packed {
    out_cnt_t events_seen;
    out_cnt_t id_matches;
    out_cnt_t in_range_matches;
    word_t    min_value;
    word_t    max_value;
    word_t    most_per_event;
    out_cnt_t duplicate_events;
  } stats_snapshot_t;

  logic     clk = 1'b0;
  logic     rst_n = 1'b0;
  logic     cfg_valid = 1'b0;
  logic     cfg_ready;
  cfg_idx_t cfg_index = '0;
  word_t    cfg_data = '0;
  logic     in_valid = 1'b0;
  logic     in_ready;
  word_t    in_id_word = '0;
  word_t    in_value_word = '0;
  logic     in_buffer_start = 1'b0;
  logic     out_valid;
  logic     out_ready = 1'b0;
  out_cnt_t out_events_seen;
  out_cnt_t out_id_matches;
  out_cnt_t out_in_range_matches;
  word_t    out_min_value;
  word_t    out_max_value;
  word_t    out_most_per_event;
  out_cnt_t out_duplicate_events;

  tagged_word_stream_monitor_unit dut (.*);

  // predicted monitor state and configuration
  word_t cur_match_id, cur_range_low, cur_range_high;
  cnt_t  event_total, match_total, in_range_total, dup_total;
  word_t lowest_seen, highest_seen, run_matches, peak_matches;

  stats_snapshot_t pending_snapshots[$];
  int failures = 0;
  int items_sent = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_asked = 0;
  int hold_served = 0;
  int hold_left = 0;

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #5ms;
    $display("== FAIL ==");
    $finish;
  end

  function automatic cnt_t bump(cnt_t c);
    return (c == '1) ? c : c + 1'b1;
  endfunction

  function automatic void monitor_reset();
    cur_match_id   = MATCH_ID_RST;
    cur_range_low  = RANGE_LO_RST;
    cur_range_high = RANGE_HI_RST;
    event_total    = '0;
    match_total    = '0;
    in_range_total = '0;
    dup_total      = '0;
    lowest_seen    = MIN_VALUE_RST;
    highest_seen   = '0;
    run_matches    = '0;
    peak_matches   = '0;
  endfunction

  function automatic void apply_pair(word_t id, word_t val, logic bs);
    stats_snapshot_t s;
    if (bs) run_matches = '0;
    if (id == END_OF_EVENT) begin
      event_total = bump(event_total);
      if (run_matches > peak_matches) peak_matches = run_matches;
      if (run_matches > 16'd1) dup_total = bump(dup_total);
      run_matches = '0;
    end
    // a delimiter may also be the matched id, so this is not an else
    if (id == cur_match_id) begin
      if (run_matches != '1) run_matches++;
      if (val >= cur_range_low && val <= cur_range_high)
        in_range_total = bump(in_range_total);
      if (val < lowest_seen) lowest_seen = val;
      if (val > highest_seen) highest_seen = val;
      match_total = bump(match_total);
    end
    s.events_seen      = out_cnt_t'(event_total);
    s.id_matches       = out_cnt_t'(match_total);
    s.in_range_matches = out_cnt_t'(in_range_total);
    s.min_value        = lowest_seen;
    s.max_value        = highest_seen;
    s.most_per_event   = peak_matches;
    s.duplicate_events = out_cnt_t'(dup_total);
    pending_snapshots.push_back(s);
  endfunction

  function automatic void compare_field(string field, longint unsigned exp_v,
                                        longint unsigned act_v);
    if (exp_v != act_v) begin
      failures++;
      if (failures <= MAX_SHOWN)
        $display("%0t: %s mismatch, expected %0d got %0d", $realtime, field, exp_v, act_v);
    end
  endfunction

  function automatic void check_snapshot();
    stats_snapshot_t exp_s;
    if (pending_snapshots.size() == 0) begin
      failures++;
      if (failures <= MAX_SHOWN)
        $display("%0t: result with no item outstanding", $realtime);
      return;
    end
    exp_s = pending_snapshots.pop_front();
    compare_field("events_seen", exp_s.events_seen, out_events_seen);
    compare_field("id_matches", exp_s.id_matches, out_id_matches);
    compare_field("in_range_matches", exp_s.in_range_matches, out_in_range_matches);
    compare_field("min_value", exp_s.min_value, out_min_value);
    compare_field("max_value", exp_s.max_value, out_max_value);
    compare_field("most_per_event", exp_s.most_per_event, out_most_per_event);
    compare_field("duplicate_events", exp_s.duplicate_events, out_duplicate_events);
  endfunction

  // result side: check on handshake, then pick next ready (random or held off)
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) check_snapshot();
    if (hold_asked != hold_served) begin
      hold_served <= hold_asked;
      hold_left   <= HOLD_CYCLES - 1;
      out_ready   <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  task automatic send_pair(word_t id, word_t val, logic bs);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_id_word      <= id;
    in_value_word   <= val;
    in_buffer_start <= bs;
    do @(posedge clk); while (!in_ready);
    apply_pair(id, val, bs);
    items_sent++;
  endtask

  // block goes idle: every result back, then a settle wait for the pipeline
  task automatic drain_results();
    int waited;
    waited = 0;
    in_valid <= 1'b0;
    while (pending_snapshots.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(cfg_idx_t idx, word_t data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_MATCH_ID:   cur_match_id = data;
      REG_RANGE_LOW:  cur_range_low = data;
      REG_RANGE_HIGH: cur_range_high = data;
      default: ;
    endcase
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  function automatic word_t pick_id();
    case ($urandom_range(0, 3))
      0, 1:    return cur_match_id;
      2:       return cur_match_id ^ word_t'(1 << $urandom_range(0, 15));
      default: return word_t'($urandom);
    endcase
  endfunction

  function automatic word_t pick_value();
    case ($urandom_range(0, 5))
      0:       return cur_range_low;
      1:       return cur_range_high;
      2:       return cur_range_low - 1'b1;
      3:       return cur_range_high + 1'b1;
      4:       return $urandom_range(0, 1) ? '1 : '0;
      default: return word_t'($urandom);
    endcase
  endfunction

  // reset configuration: range edges, id neighbors, event closing rules
  task automatic test_directed_pairs();
    send_pair(END_OF_EVENT, 16'h0000, 1'b1);
    send_pair(MATCH_ID_RST, 16'h0000, 1'b0);
    send_pair(MATCH_ID_RST, RANGE_LO_RST, 1'b0);
    send_pair(MATCH_ID_RST, RANGE_HI_RST, 1'b0);
    send_pair(MATCH_ID_RST, RANGE_HI_RST + 1'b1, 1'b0);
    send_pair(MATCH_ID_RST, 16'hFFFF, 1'b0);
    send_pair(16'h8000, 16'h1234, 1'b0);
    send_pair(16'h0000, 16'h0001, 1'b0);
    send_pair(16'hFFFE, 16'hFFFF, 1'b0);
    send_pair(END_OF_EVENT, 16'hFFFF, 1'b0);
    send_pair(MATCH_ID_RST, 16'd100, 1'b0);
    send_pair(END_OF_EVENT, 16'h0000, 1'b0);
    send_pair(MATCH_ID_RST, 16'd200, 1'b0);
    send_pair(MATCH_ID_RST, 16'd300, 1'b1);
    send_pair(END_OF_EVENT, 16'h0000, 1'b0);
    send_pair(MATCH_ID_RST, 16'h5555, 1'b0);
    send_pair(MATCH_ID_RST, 16'hAAAA, 1'b0);
    send_pair(END_OF_EVENT, 16'h5555, 1'b1);
    send_pair(16'hAAAA, 16'h5555, 1'b1);
    drain_results();
  endtask

  // delimiter id is also the matched id: closes one event, opens the next
  task automatic test_delimiter_match();
    write_reg(REG_MATCH_ID, END_OF_EVENT);
    write_reg(REG_RANGE_LOW, 16'h0000);
    write_reg(REG_RANGE_HIGH, 16'hFFFF);
    send_pair(END_OF_EVENT, 16'h0000, 1'b0);
    send_pair(END_OF_EVENT, 16'hFFFF, 1'b0);
    send_pair(16'h8001, 16'h0007, 1'b0);
    send_pair(END_OF_EVENT, 16'h0007, 1'b1);
    send_pair(END_OF_EVENT, 16'h8000, 1'b0);
    drain_results();
  endtask

  // empty and single-point ranges, plus a write to an index with no register
  task automatic test_range_bounds();
    write_reg(REG_MATCH_ID, 16'h0000);
    write_reg(REG_RANGE_LOW, 16'hFFFF);
    write_reg(REG_RANGE_HIGH, 16'h0000);
    send_pair(16'h0000, 16'h0000, 1'b1);
    send_pair(16'h0000, 16'hFFFF, 1'b0);
    send_pair(16'h0000, 16'h8000, 1'b0);
    drain_results();
    write_reg(REG_UNUSED, 16'hFFFF);
    write_reg(REG_RANGE_LOW, 16'h8000);
    write_reg(REG_RANGE_HIGH, 16'h8000);
    send_pair(16'h0000, 16'h7FFF, 1'b0);
    send_pair(16'h0000, 16'h8000, 1'b0);
    send_pair(16'h0000, 16'h8001, 1'b0);
    send_pair(END_OF_EVENT, 16'h0000, 1'b0);
    drain_results();
  endtask

  // long receiver hold-off while items keep coming, so the input stalls
  task automatic test_backpressure();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_asked <= hold_asked + 1;
    repeat (24) send_pair(pick_id(), pick_value(), $urandom_range(0, 7) == 0);
    drain_results();
    repeat (12) send_pair(pick_id(), pick_value(), 1'b0);
    send_pair(END_OF_EVENT, word_t'($urandom), 1'b0);
    drain_results();
  endtask

  task automatic test_random_traffic(int snd_pct, int rcv_pct, word_t mid,
                                     word_t lo, word_t hi, int n_items);
    int stop_at;
    int n_pairs;
    send_idle_pct = snd_pct;
    recv_idle_pct = rcv_pct;
    write_reg(REG_MATCH_ID, mid);
    write_reg(REG_RANGE_LOW, lo);
    write_reg(REG_RANGE_HIGH, hi);
    stop_at = items_sent + n_items;
    while (items_sent < stop_at) begin
      if ($urandom_range(0, 9) < 8) begin
        n_pairs = $urandom_range(0, 6);
        for (int k = 0; k < n_pairs; k++)
          send_pair(pick_id(), pick_value(), (k == 0) && ($urandom_range(0, 3) == 0));
        send_pair(END_OF_EVENT, word_t'($urandom), $urandom_range(0, 15) == 0);
      end else begin
        send_pair(word_t'($urandom), word_t'($urandom), 1'($urandom_range(0, 1)));
      end
    end
    drain_results();
  endtask

  initial begin
    monitor_reset();
    send_idle_pct = 17;
    recv_idle_pct = 73;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed_pairs();
    test_delimiter_match();
    test_range_bounds();
    test_backpressure();
    test_random_traffic(17, 73, 16'h8000 + word_t'($urandom_range(0, 15)),
                        word_t'($urandom_range(0, 4000)),
                        word_t'($urandom_range(4000, 30000)), 470);
    test_random_traffic(73, 17, word_t'($urandom), word_t'($urandom),
                        word_t'($urandom), 470);
    test_random_traffic(0, 0, END_OF_EVENT, 16'h0000, 16'hFFFF, 470);

    drain_results();
    if (failures == 0 && pending_snapshots.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
